// File: sv/pns_pkg.sv
// Shared types, constants and helpers for the polynomial normal shading block.
`default_nettype none

package pns_pkg;

  localparam int DEG_MAX    = 7;
  localparam int DEG_W      = 3;
  localparam int TERMS_MAX  = (DEG_MAX + 1) * (DEG_MAX + 1);
  localparam int IDX_W      = $clog2(TERMS_MAX);
  localparam int PW_IDX_W   = $clog2(DEG_MAX + 1);
  localparam int COEF_W     = 32;
  localparam int NORM_W     = 16;
  localparam int PW_W       = NORM_W + 1;
  localparam int PROD_W     = 2 * PW_W;
  localparam int CM_W       = COEF_W + PW_W;
  localparam int ACC_W      = CM_W + IDX_W + 1;
  localparam int RND_W      = ACC_W - 15;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic signed [COEF_W-1:0] ONE_Q16 = 32'sd65536;
  localparam logic signed [PW_W-1:0]   ONE_Q15 = 17'sd32768;
  localparam logic signed [COEF_W-1:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [COEF_W-1:0] SAT_MIN = 32'sh80000000;

  localparam logic [DEG_W-1:0] DEGREE_RST = 3'd2;
  localparam logic             REG_DEGREE = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POW,
    ST_PWB,
    ST_TERM,
    ST_DRAIN,
    ST_ROUND,
    ST_SAT
  } state_e;

  typedef enum logic [1:0] {
    CMP_X,
    CMP_Y,
    CMP_Z
  } comp_e;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [COEF_W-1:0] data;
  } coef_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } coef_rd_t;

  // round half up back to Q1.15
  function automatic logic signed [PW_W-1:0] rnd_q15(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] s;
    s = v + 34'sd16384;
    return s[PW_W+14:15];
  endfunction

  // (g+1)^2
  function automatic logic [IDX_W:0] term_count(input logic [DEG_W-1:0] g);
    logic [IDX_W:0] gp;
    gp = (IDX_W + 1)'(g) + 1'b1;
    return (IDX_W + 1)'(gp * gp);
  endfunction

endpackage

`default_nettype wire

// File: sv/pns_coef_store.sv
// Coefficient memory with per-entry valid bits; unwritten entries read as 1.0.
`default_nettype none

module pns_coef_store (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire pns_pkg::coef_wr_t                   wr_i,
  input  wire pns_pkg::coef_rd_t                   rd_i,
  output logic signed [pns_pkg::COEF_W-1:0]        rd_data_o
);

  logic [pns_pkg::COEF_W-1:0] mem [pns_pkg::TERMS_MAX];
  logic [pns_pkg::TERMS_MAX-1:0] vld_q;
  logic [pns_pkg::COEF_W-1:0] rd_q;
  logic vld_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_q <= mem[rd_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_i.en) begin
        vld_rd_q <= vld_q[rd_i.addr];
      end
    end
  end

  assign rd_data_o = vld_rd_q ? $signed(rd_q) : pns_pkg::ONE_Q16;

endmodule

`default_nettype wire

// File: sv/polynomial_normal_shading.sv
// Top level: trivariate shading polynomial evaluator with coefficient memory.
// An evaluate runs power setup, the term walk, a pipeline drain, a round and a clip before
// its result strobe. Power setup runs one product a cycle on one multiplier; terms
// stream one a cycle through a five-stage multiply pipeline fed by the coefficient memory.
// A load gives no result and leaves busy low; the next word is taken in the strobe cycle.
// Results cannot be stalled. Reset: degree 2, all coefficients read as 1.0 via valid bits.
`default_nettype none

module polynomial_normal_shading (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    psel,
  input  wire logic                                    penable,
  input  wire logic                                    pwrite,
  input  wire logic [pns_pkg::APB_ADDR_W-1:0]          paddr,
  input  wire logic [pns_pkg::APB_DATA_W-1:0]          pwdata,
  output logic      [pns_pkg::APB_DATA_W-1:0]          prdata,
  output logic                                         pready,
  input  wire logic                                    start,
  output logic                                         busy,
  input  wire logic                                    req_type_i,
  input  wire logic [pns_pkg::IDX_W-1:0]               coef_index_i,
  input  wire logic signed [pns_pkg::COEF_W-1:0]       coef_value_i,
  input  wire logic signed [pns_pkg::NORM_W-1:0]       norm_x_i,
  input  wire logic signed [pns_pkg::NORM_W-1:0]       norm_y_i,
  input  wire logic signed [pns_pkg::NORM_W-1:0]       norm_z_i,
  output logic                                         result_valid_o,
  output logic signed [pns_pkg::COEF_W-1:0]            shade_value_o,
  output logic                                         saturated_o
);

  localparam int PW_W = pns_pkg::PW_W;

  pns_pkg::state_e state_q, state_d;
  logic [pns_pkg::DEG_W-1:0] degree_q;

  logic accept, eval_start;
  pns_pkg::coef_wr_t wr;
  pns_pkg::coef_rd_t rd;
  logic signed [pns_pkg::COEF_W-1:0] coef_rd;

  // power setup
  logic signed [PW_W-1:0] nx_q, ny_q, nz_q;
  logic signed [PW_W-1:0] run_x_q, run_y_q, run_z_q;
  logic signed [PW_W-1:0] pw_x_q [pns_pkg::DEG_MAX+1];
  logic signed [PW_W-1:0] pw_y_q [pns_pkg::DEG_MAX+1];
  logic signed [PW_W-1:0] pw_z_q [pns_pkg::DEG_MAX+1];
  logic [pns_pkg::PW_IDX_W-1:0] pw_p_q, pm_p_q;
  pns_pkg::comp_e pw_c_q, pm_c_q;
  logic pm_vld_q;
  logic signed [pns_pkg::PROD_W-1:0] pm_prod_q;
  logic signed [PW_W-1:0] run_sel, norm_sel, pm_rnd;

  // term walk
  logic [pns_pkg::DEG_W-1:0] d_q, i_q, j_q, k_cur;
  logic [pns_pkg::IDX_W-1:0] t_q;
  logic term_last;

  // term pipeline
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q;
  logic signed [pns_pkg::PROD_W-1:0] s1_xy_q, s3_mz_q;
  logic [pns_pkg::DEG_W-1:0] s1_k_q, s2_k_q;
  logic signed [PW_W-1:0] s2_m1_q, s4_m_q;
  logic signed [pns_pkg::COEF_W-1:0] s2_coef_q, s3_coef_q, s4_coef_q;
  logic signed [pns_pkg::CM_W-1:0] s5_cm_q;
  logic signed [pns_pkg::ACC_W-1:0] acc_q, acc_rnd;
  logic signed [pns_pkg::RND_W-1:0] rnd_q;
  logic pipe_busy;

  logic res_vld_q, res_sat_q;
  logic signed [pns_pkg::COEF_W-1:0] res_val_q;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == pns_pkg::REG_DEGREE) ?
                  {{(pns_pkg::APB_DATA_W - pns_pkg::DEG_W){1'b0}}, degree_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= pns_pkg::DEGREE_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == pns_pkg::REG_DEGREE) begin
      degree_q <= pwdata[pns_pkg::DEG_W-1:0];
    end
  end

  assign busy       = (state_q != pns_pkg::ST_IDLE);
  assign accept     = start && !busy;
  assign eval_start = accept && req_type_i;

  assign wr.en   = accept && !req_type_i &&
                   ({1'b0, coef_index_i} < pns_pkg::term_count(degree_q));
  assign wr.addr = coef_index_i;
  assign wr.data = coef_value_i;
  assign rd.en   = (state_q == pns_pkg::ST_TERM);
  assign rd.addr = t_q;

  pns_coef_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .rd_i      (rd),
    .rd_data_o (coef_rd)
  );

  assign k_cur     = d_q - i_q - j_q;
  assign term_last = (j_q == '0) && (i_q == '0) && ((d_q != degree_q) || (degree_q == '0));
  assign pipe_busy = s1_vld_q || s2_vld_q || s3_vld_q || s4_vld_q || s5_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pns_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pns_pkg::ST_IDLE: begin
        if (eval_start) begin
          state_d = (degree_q == '0) ? pns_pkg::ST_PWB : pns_pkg::ST_POW;
        end
      end
      pns_pkg::ST_POW: begin
        if (pw_p_q == degree_q && pw_c_q == pns_pkg::CMP_Z) begin
          state_d = pns_pkg::ST_PWB;
        end
      end
      pns_pkg::ST_PWB:   state_d = pns_pkg::ST_TERM;
      pns_pkg::ST_TERM: begin
        if (term_last) begin
          state_d = pns_pkg::ST_DRAIN;
        end
      end
      pns_pkg::ST_DRAIN: begin
        if (!pipe_busy) begin
          state_d = pns_pkg::ST_ROUND;
        end
      end
      pns_pkg::ST_ROUND: state_d = pns_pkg::ST_SAT;
      pns_pkg::ST_SAT:   state_d = pns_pkg::ST_IDLE;
      default:           state_d = pns_pkg::ST_IDLE;
    endcase
  end

  // counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_p_q   <= '0;
      pw_c_q   <= pns_pkg::CMP_X;
      pm_vld_q <= 1'b0;
      d_q      <= '0;
      i_q      <= '0;
      j_q      <= '0;
      t_q      <= '0;
    end else begin
      pm_vld_q <= (state_q == pns_pkg::ST_POW);
      if (eval_start) begin
        pw_p_q <= pns_pkg::PW_IDX_W'(1);
        pw_c_q <= pns_pkg::CMP_X;
        d_q    <= degree_q;
        i_q    <= degree_q;
        j_q    <= '0;
        t_q    <= '0;
      end else if (state_q == pns_pkg::ST_POW) begin
        if (pw_c_q == pns_pkg::CMP_Z) begin
          pw_c_q <= pns_pkg::CMP_X;
          pw_p_q <= pw_p_q + 1'b1;
        end else if (pw_c_q == pns_pkg::CMP_X) begin
          pw_c_q <= pns_pkg::CMP_Y;
        end else begin
          pw_c_q <= pns_pkg::CMP_Z;
        end
      end else if (state_q == pns_pkg::ST_TERM) begin
        t_q <= t_q + 1'b1;
        if (j_q != '0) begin
          j_q <= j_q - 1'b1;
        end else if (i_q != '0) begin
          i_q <= i_q - 1'b1;
          j_q <= d_q - i_q + 1'b1;
        end else begin
          d_q <= d_q - 1'b1;
          i_q <= d_q - 1'b1;
          j_q <= '0;
        end
      end
    end
  end

  always_comb begin
    case (pw_c_q)
      pns_pkg::CMP_X: begin
        run_sel  = run_x_q;
        norm_sel = nx_q;
      end
      pns_pkg::CMP_Y: begin
        run_sel  = run_y_q;
        norm_sel = ny_q;
      end
      default: begin
        run_sel  = run_z_q;
        norm_sel = nz_q;
      end
    endcase
  end

  assign pm_rnd = pns_pkg::rnd_q15(pm_prod_q);

  // power tables
  always_ff @(posedge clk_i) begin
    if (eval_start) begin
      nx_q      <= {norm_x_i[pns_pkg::NORM_W-1], norm_x_i};
      ny_q      <= {norm_y_i[pns_pkg::NORM_W-1], norm_y_i};
      nz_q      <= {norm_z_i[pns_pkg::NORM_W-1], norm_z_i};
      run_x_q   <= pns_pkg::ONE_Q15;
      run_y_q   <= pns_pkg::ONE_Q15;
      run_z_q   <= pns_pkg::ONE_Q15;
      pw_x_q[0] <= pns_pkg::ONE_Q15;
      pw_y_q[0] <= pns_pkg::ONE_Q15;
      pw_z_q[0] <= pns_pkg::ONE_Q15;
    end else if (pm_vld_q) begin
      case (pm_c_q)
        pns_pkg::CMP_X: begin
          pw_x_q[pm_p_q] <= pm_rnd;
          run_x_q        <= pm_rnd;
        end
        pns_pkg::CMP_Y: begin
          pw_y_q[pm_p_q] <= pm_rnd;
          run_y_q        <= pm_rnd;
        end
        default: begin
          pw_z_q[pm_p_q] <= pm_rnd;
          run_z_q        <= pm_rnd;
        end
      endcase
    end
    pm_prod_q <= run_sel * norm_sel;
    pm_p_q    <= pw_p_q;
    pm_c_q    <= pw_c_q;
  end

  // term pipeline: xy product, round, times z^k, round, times coefficient, accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= (state_q == pns_pkg::ST_TERM);
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_xy_q   <= pw_x_q[i_q] * pw_y_q[j_q];
    s1_k_q    <= k_cur;
    s2_m1_q   <= pns_pkg::rnd_q15(s1_xy_q);
    s2_k_q    <= s1_k_q;
    s2_coef_q <= coef_rd;
    s3_mz_q   <= s2_m1_q * pw_z_q[s2_k_q];
    s3_coef_q <= s2_coef_q;
    s4_m_q    <= pns_pkg::rnd_q15(s3_mz_q);
    s4_coef_q <= s3_coef_q;
    s5_cm_q   <= s4_coef_q * s4_m_q;
    if (eval_start) begin
      acc_q <= '0;
    end else if (s5_vld_q) begin
      acc_q <= acc_q + {{(pns_pkg::ACC_W - pns_pkg::CM_W){s5_cm_q[pns_pkg::CM_W-1]}}, s5_cm_q};
    end
  end

  assign acc_rnd = acc_q + pns_pkg::ACC_W'(16384);

  // final round and clip
  always_ff @(posedge clk_i) begin
    if (state_q == pns_pkg::ST_ROUND) begin
      rnd_q <= acc_rnd[pns_pkg::ACC_W-1:15];
    end
    if (state_q == pns_pkg::ST_SAT) begin
      if (rnd_q[pns_pkg::RND_W-1:pns_pkg::COEF_W-1] == '0 ||
          rnd_q[pns_pkg::RND_W-1:pns_pkg::COEF_W-1] == '1) begin
        res_val_q <= rnd_q[pns_pkg::COEF_W-1:0];
        res_sat_q <= 1'b0;
      end else if (rnd_q[pns_pkg::RND_W-1]) begin
        res_val_q <= pns_pkg::SAT_MIN;
        res_sat_q <= 1'b1;
      end else begin
        res_val_q <= pns_pkg::SAT_MAX;
        res_sat_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= (state_q == pns_pkg::ST_SAT);
    end
  end

  assign result_valid_o = res_vld_q;
  assign shade_value_o  = res_val_q;
  assign saturated_o    = res_sat_q;

endmodule

`default_nettype wire

// File: sv/pns_checker.sv
// Port-level checks for the shading evaluator, bound to the top level.
`default_nettype none

module pns_checker (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 start,
  input wire logic                                 busy,
  input wire logic                                 req_type_i,
  input wire logic                                 result_valid_o,
  input wire logic signed [pns_pkg::COEF_W-1:0]    shade_value_o,
  input wire logic                                 saturated_o
);

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_type_i |=> busy && !result_valid_o)
    else $error("evaluate word did not start");

  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !req_type_i |=> !busy && !result_valid_o)
    else $error("load word made the block busy or gave a result");

  a_done_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("evaluate finished without a result");

  a_sat_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && saturated_o |->
      shade_value_o == pns_pkg::SAT_MAX || shade_value_o == pns_pkg::SAT_MIN)
    else $error("saturated flag with unclipped value");

endmodule

bind polynomial_normal_shading pns_checker u_pns_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .req_type_i     (req_type_i),
  .result_valid_o (result_valid_o),
  .shade_value_o  (shade_value_o),
  .saturated_o    (saturated_o)
);

`default_nettype wire
